[src/differential_odometry_update_macros.svh]
// assertion macros for the odometry update block
// used by the controller; the bodies are empty when SYNTHESIS is defined
`ifndef DIFFERENTIAL_ODOMETRY_UPDATE_MACROS_SVH
`define DIFFERENTIAL_ODOMETRY_UPDATE_MACROS_SVH

`ifndef SYNTHESIS
`define DOU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DOU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DOU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define DOU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[src/dou_pkg.sv]
// shared types, constants and trig table function for the odometry update block
// no dependencies
package dou_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned TRIG_BITS_DEF = 16;

    localparam int unsigned CNT_W   = 32;
    localparam int unsigned HEAD_W  = 16;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned SCALE_W = 24;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd58104;

    // |sum| * scale split into two multiplier passes
    localparam int unsigned SUM_W     = CNT_W + 1;
    localparam int unsigned SUM_SPLIT = 17;
    localparam int unsigned MAG_W     = SUM_W + SCALE_W;
    localparam int unsigned MA_W      = 29;

    localparam int unsigned DELTA_W = 63;
    localparam longint unsigned DELTA_CAP = 64'd1 << 62;
    localparam int unsigned SAT_W = DELTA_W + 2;

    // heading reduction
    localparam int unsigned DEG_FULL   = 360;
    localparam int unsigned DEG_QUAD   = 90;
    localparam int unsigned DEG_OCT    = 45;
    localparam int unsigned HEAD_U_W   = 17;
    localparam int unsigned HEAD_BIAS  = 92 * DEG_FULL;
    localparam int unsigned RECIP_SH   = 25;
    localparam int unsigned HEAD_RECIP = ((2 ** RECIP_SH) + DEG_FULL - 1) / DEG_FULL;
    localparam int unsigned HEAD_Q_W   = 8;
    localparam int unsigned H_W        = 9;
    localparam int unsigned R_W        = 7;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SUM,
        ST_ABS,
        ST_QUAD,
        ST_TRIG,
        ST_MSUM_LO,
        ST_MSUM_HI,
        ST_MAG,
        ST_X_LO,
        ST_X_HI,
        ST_X_WIDE,
        ST_X_CAP,
        ST_X_ACC,
        ST_Y_LO,
        ST_Y_HI,
        ST_Y_WIDE,
        ST_Y_CAP,
        ST_Y_ACC,
        ST_OUT
    } dou_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DELTA,
        OP_SUM,
        OP_ABS,
        OP_QUAD,
        OP_TRIG,
        OP_MSUM_LO,
        OP_MSUM_HI,
        OP_MAG,
        OP_MW_LO,
        OP_MW_HI,
        OP_WIDE,
        OP_CAP,
        OP_ACC,
        OP_OUT
    } dou_op_t;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } dou_quad_t;

    typedef struct packed {
        dou_op_t op;
        logic    axis_y;
    } dou_cmd_t;

    typedef struct packed {
        logic out_free;
    } dou_sts_t;

    // one horner term divisor, sine or cosine series
    function automatic longint unsigned horner_div(input longint unsigned p,
                                                   input int unsigned i,
                                                   input logic want_cos);
        longint unsigned q;
        if (want_cos)
        begin
            unique case (i)
                0:       q = p / 90;
                1:       q = p / 56;
                2:       q = p / 30;
                3:       q = p / 12;
                default: q = p / 2;
            endcase
        end
        else
        begin
            unique case (i)
                0:       q = p / 110;
                1:       q = p / 72;
                2:       q = p / 42;
                3:       q = p / 20;
                default: q = p / 6;
            endcase
        end
        return q;
    endfunction

    // sine or cosine of r degrees, r up to 45, rounded to tbits fraction bits
    function automatic logic [31:0] trig_base(input int unsigned r, input logic want_cos,
                                              input int unsigned tbits);
        longint unsigned x;
        longint unsigned t;
        longint unsigned acc;
        longint unsigned p;
        x = 64'(r) * RAD_PER_DEG_Q30;
        t = (x * x) >> 30;
        acc = Q30_ONE;
        for (int i = 0; i < 5; i++)
        begin
            p = (t * acc) >> 30;
            acc = Q30_ONE - horner_div(p, i, want_cos);
        end
        if (!want_cos)
        begin
            acc = (x * acc) >> 30;
        end
        return 32'((acc + (64'd1 << (29 - tbits))) >> (30 - tbits));
    endfunction

    // sine or cosine of r degrees, r up to 89
    function automatic logic [31:0] trig_quarter(input int unsigned r, input logic want_cos,
                                                 input int unsigned tbits);
        if (r <= DEG_OCT)
        begin
            return trig_base(r, want_cos, tbits);
        end
        return trig_base(DEG_QUAD - r, !want_cos, tbits);
    endfunction

endpackage

[src/dou_ifs.sv]
// valid/ready channel interfaces for samples and position results
// depends on dou_pkg
interface dou_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [dou_pkg::CNT_W-1:0]    left_count;
    logic signed [dou_pkg::CNT_W-1:0]    right_count;
    logic signed [dou_pkg::HEAD_W-1:0]   heading_deg;

    modport source (output valid, left_count, right_count, heading_deg, input ready);
    modport sink (input valid, left_count, right_count, heading_deg, output ready);
endinterface

interface dou_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [dou_pkg::POS_W-1:0]    pos_x_mm;
    logic signed [dou_pkg::POS_W-1:0]    pos_y_mm;
    logic signed [dou_pkg::HEAD_W-1:0]   heading_out_deg;

    modport source (output valid, pos_x_mm, pos_y_mm, heading_out_deg, input ready);
    modport sink (input valid, pos_x_mm, pos_y_mm, heading_out_deg, output ready);
endinterface

[src/dou_dp.sv]
// datapath: count deltas, heading reduction, trig tables, shared multiplier,
// saturating accumulators and output register; depends on dou_pkg
module dou_dp #(
    parameter int unsigned FRAC_BITS = dou_pkg::FRAC_BITS_DEF,
    parameter int unsigned TRIG_BITS = dou_pkg::TRIG_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dou_pkg::dou_cmd_t                   cmd,
    output dou_pkg::dou_sts_t                   sts,
    input  logic                                cfg_wr_en,
    input  logic [dou_pkg::SCALE_W-1:0]         cfg_wr_data,
    input  logic signed [dou_pkg::CNT_W-1:0]    left_count,
    input  logic signed [dou_pkg::CNT_W-1:0]    right_count,
    input  logic signed [dou_pkg::HEAD_W-1:0]   heading_deg,
    input  logic                                result_ready,
    output logic                                result_valid,
    output logic signed [dou_pkg::POS_W-1:0]    pos_x_mm,
    output logic signed [dou_pkg::POS_W-1:0]    pos_y_mm,
    output logic signed [dou_pkg::HEAD_W-1:0]   heading_out_deg
);

    localparam int unsigned TRIG_W  = TRIG_BITS + 1;
    localparam int unsigned MB_W    = (TRIG_W > dou_pkg::SCALE_W) ? TRIG_W : dou_pkg::SCALE_W;
    localparam int unsigned PROD_W  = dou_pkg::MA_W + MB_W;
    localparam int unsigned WIDE_W  = dou_pkg::MAG_W + TRIG_W;
    localparam int unsigned N_SHIFT = 17 + TRIG_BITS - FRAC_BITS;
    localparam int unsigned ACC_W   = 32 + FRAC_BITS;
    localparam int unsigned HQ_W    = 2 * dou_pkg::HEAD_U_W;

    localparam logic [dou_pkg::HEAD_U_W-1:0] HEAD_RECIP_C =
        dou_pkg::HEAD_U_W'(dou_pkg::HEAD_RECIP);
    localparam logic [dou_pkg::HEAD_U_W-1:0] DEG_FULL_C =
        dou_pkg::HEAD_U_W'(dou_pkg::DEG_FULL);
    localparam logic [dou_pkg::H_W-1:0] DEG_90  = dou_pkg::H_W'(dou_pkg::DEG_QUAD);
    localparam logic [dou_pkg::H_W-1:0] DEG_180 = dou_pkg::H_W'(2 * dou_pkg::DEG_QUAD);
    localparam logic [dou_pkg::H_W-1:0] DEG_270 = dou_pkg::H_W'(3 * dou_pkg::DEG_QUAD);
    localparam logic [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);

    // constant sine and cosine tables over one quadrant
    logic [TRIG_W-1:0] sin_tbl [dou_pkg::DEG_QUAD];
    logic [TRIG_W-1:0] cos_tbl [dou_pkg::DEG_QUAD];

    for (genvar g = 0; g < dou_pkg::DEG_QUAD; g++)
    begin : g_trig
        assign sin_tbl[g] = TRIG_W'(dou_pkg::trig_quarter(g, 1'b0, TRIG_BITS));
        assign cos_tbl[g] = TRIG_W'(dou_pkg::trig_quarter(g, 1'b1, TRIG_BITS));
    end

    logic [dou_pkg::SCALE_W-1:0]         scale_reg;
    logic [dou_pkg::CNT_W-1:0]           prev_left_reg;
    logic [dou_pkg::CNT_W-1:0]           prev_right_reg;
    logic signed [ACC_W-1:0]             x_acc_reg;
    logic signed [ACC_W-1:0]             y_acc_reg;
    logic                                out_valid_reg;

    logic [dou_pkg::CNT_W-1:0]           cl_reg;
    logic [dou_pkg::CNT_W-1:0]           cr_reg;
    logic signed [dou_pkg::HEAD_W-1:0]   hd_reg;
    logic [dou_pkg::CNT_W-1:0]           dl_reg;
    logic [dou_pkg::CNT_W-1:0]           dr_reg;
    logic [dou_pkg::SUM_W-1:0]           sum_reg;
    logic [dou_pkg::SUM_W-1:0]           abs_reg;
    logic                                neg_reg;
    logic [dou_pkg::HEAD_U_W-1:0]        u_reg;
    logic [dou_pkg::HEAD_Q_W-1:0]        q360_reg;
    logic [dou_pkg::H_W-1:0]             h_reg;
    dou_pkg::dou_quad_t                  quad_reg;
    logic [dou_pkg::R_W-1:0]             r_reg;
    logic [TRIG_W-1:0]                   sn_mag_reg;
    logic [TRIG_W-1:0]                   cs_mag_reg;
    logic                                sn_neg_reg;
    logic                                cs_neg_reg;
    logic [PROD_W-1:0]                   prod_reg;
    logic [dou_pkg::MAG_W-1:0]           mag_reg;
    logic [WIDE_W-1:0]                   wide_reg;
    logic [dou_pkg::DELTA_W-1:0]         dmag_reg;
    logic                                dneg_reg;
    logic signed [dou_pkg::POS_W-1:0]    pos_x_reg;
    logic signed [dou_pkg::POS_W-1:0]    pos_y_reg;
    logic signed [dou_pkg::HEAD_W-1:0]   hd_out_reg;

    logic [dou_pkg::MA_W-1:0]            mul_a;
    logic [MB_W-1:0]                     mul_b;
    logic                                mul_en;
    logic [TRIG_W-1:0]                   trig_mag;
    logic [HQ_W-1:0]                     q_prod;
    logic [dou_pkg::HEAD_U_W-1:0]        h_full;
    logic [TRIG_W-1:0]                   sb;
    logic [TRIG_W-1:0]                   cb;
    logic [TRIG_W-1:0]                   sn_sel;
    logic [TRIG_W-1:0]                   cs_sel;
    logic                                sn_neg_sel;
    logic                                cs_neg_sel;
    logic [WIDE_W-1:0]                   shifted;
    logic signed [ACC_W-1:0]             acc_cur;
    logic signed [dou_pkg::SAT_W-1:0]    acc_ext;
    logic signed [dou_pkg::SAT_W-1:0]    d_ext;
    logic signed [dou_pkg::SAT_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]             acc_new;
    logic                                sat_hi;
    logic                                sat_lo;
    logic [ACC_W-1:0]                    x_bias;
    logic [ACC_W-1:0]                    y_bias;

    // shared multiplier operand select
    assign trig_mag = cmd.axis_y ? cs_mag_reg : sn_mag_reg;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (cmd.op)
            dou_pkg::OP_MSUM_LO:
            begin
                mul_a = dou_pkg::MA_W'(abs_reg[dou_pkg::SUM_SPLIT-1:0]);
                mul_b = MB_W'(scale_reg);
            end
            dou_pkg::OP_MSUM_HI:
            begin
                mul_a = dou_pkg::MA_W'(abs_reg[dou_pkg::SUM_W-1:dou_pkg::SUM_SPLIT]);
                mul_b = MB_W'(scale_reg);
            end
            dou_pkg::OP_MW_LO:
            begin
                mul_a = mag_reg[dou_pkg::MA_W-1:0];
                mul_b = MB_W'(trig_mag);
            end
            dou_pkg::OP_MW_HI:
            begin
                mul_a = dou_pkg::MA_W'(mag_reg[dou_pkg::MAG_W-1:dou_pkg::MA_W]);
                mul_b = MB_W'(trig_mag);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // heading modulo 360 through a reciprocal
    assign q_prod = HQ_W'(u_reg) * HQ_W'(HEAD_RECIP_C);
    assign h_full = u_reg - dou_pkg::HEAD_U_W'(dou_pkg::HEAD_U_W'(q360_reg) * DEG_FULL_C);

    // quadrant folding of the table values
    always_comb
    begin
        sb = sin_tbl[r_reg];
        cb = cos_tbl[r_reg];
        unique case (quad_reg)
            dou_pkg::QUAD_0:
            begin
                sn_sel = sb; sn_neg_sel = 1'b0;
                cs_sel = cb; cs_neg_sel = 1'b0;
            end
            dou_pkg::QUAD_1:
            begin
                sn_sel = cb; sn_neg_sel = 1'b0;
                cs_sel = sb; cs_neg_sel = 1'b1;
            end
            dou_pkg::QUAD_2:
            begin
                sn_sel = sb; sn_neg_sel = 1'b1;
                cs_sel = cb; cs_neg_sel = 1'b1;
            end
            default:
            begin
                sn_sel = cb; sn_neg_sel = 1'b1;
                cs_sel = sb; cs_neg_sel = 1'b0;
            end
        endcase
    end

    assign shifted = wide_reg >> N_SHIFT;

    // saturating accumulate
    always_comb
    begin
        acc_cur = cmd.axis_y ? y_acc_reg : x_acc_reg;
        acc_ext = dou_pkg::SAT_W'(acc_cur);
        d_ext   = signed'(dou_pkg::SAT_W'(dmag_reg));
        acc_sum = dneg_reg ? (acc_ext - d_ext) : (acc_ext + d_ext);
        sat_hi  = !acc_sum[dou_pkg::SAT_W-1] && (|acc_sum[dou_pkg::SAT_W-2:ACC_W-1]);
        sat_lo  = acc_sum[dou_pkg::SAT_W-1] && !(&acc_sum[dou_pkg::SAT_W-2:ACC_W-1]);
        priority if (sat_hi)
        begin
            acc_new = {1'b0, {(ACC_W-1){1'b1}}};
        end
        else if (sat_lo)
        begin
            acc_new = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            acc_new = acc_sum[ACC_W-1:0];
        end
    end

    // truncation toward zero of the millimetre outputs
    assign x_bias = x_acc_reg + (x_acc_reg[ACC_W-1] ? TRUNC_BIAS : '0);
    assign y_bias = y_acc_reg + (y_acc_reg[ACC_W-1] ? TRUNC_BIAS : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= dou_pkg::SCALE_RESET;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            x_acc_reg      <= '0;
            y_acc_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
            if (cmd.op == dou_pkg::OP_DELTA)
            begin
                prev_left_reg  <= cl_reg;
                prev_right_reg <= cr_reg;
            end
            if (cmd.op == dou_pkg::OP_ACC)
            begin
                if (cmd.axis_y)
                begin
                    y_acc_reg <= acc_new;
                end
                else
                begin
                    x_acc_reg <= acc_new;
                end
            end
            if (cmd.op == dou_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        unique case (cmd.op)
            dou_pkg::OP_LOAD:
            begin
                cl_reg <= left_count;
                cr_reg <= right_count;
                hd_reg <= heading_deg;
            end
            dou_pkg::OP_DELTA:
            begin
                dl_reg <= cl_reg - prev_left_reg;
                dr_reg <= cr_reg - prev_right_reg;
                u_reg  <= dou_pkg::HEAD_U_W'({{2{hd_reg[dou_pkg::HEAD_W-1]}}, hd_reg}
                          + 18'(dou_pkg::HEAD_BIAS));
            end
            dou_pkg::OP_SUM:
            begin
                sum_reg  <= {dl_reg[dou_pkg::CNT_W-1], dl_reg}
                            + {dr_reg[dou_pkg::CNT_W-1], dr_reg};
                q360_reg <= q_prod[dou_pkg::RECIP_SH+dou_pkg::HEAD_Q_W-1:dou_pkg::RECIP_SH];
            end
            dou_pkg::OP_ABS:
            begin
                neg_reg <= sum_reg[dou_pkg::SUM_W-1];
                abs_reg <= sum_reg[dou_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
                h_reg   <= h_full[dou_pkg::H_W-1:0];
            end
            dou_pkg::OP_QUAD:
            begin
                priority if (h_reg >= DEG_270)
                begin
                    quad_reg <= dou_pkg::QUAD_3;
                    r_reg    <= dou_pkg::R_W'(h_reg - DEG_270);
                end
                else if (h_reg >= DEG_180)
                begin
                    quad_reg <= dou_pkg::QUAD_2;
                    r_reg    <= dou_pkg::R_W'(h_reg - DEG_180);
                end
                else if (h_reg >= DEG_90)
                begin
                    quad_reg <= dou_pkg::QUAD_1;
                    r_reg    <= dou_pkg::R_W'(h_reg - DEG_90);
                end
                else
                begin
                    quad_reg <= dou_pkg::QUAD_0;
                    r_reg    <= dou_pkg::R_W'(h_reg);
                end
            end
            dou_pkg::OP_TRIG:
            begin
                sn_mag_reg <= sn_sel;
                cs_mag_reg <= cs_sel;
                sn_neg_reg <= sn_neg_sel;
                cs_neg_reg <= cs_neg_sel;
            end
            dou_pkg::OP_MSUM_HI:
            begin
                mag_reg <= dou_pkg::MAG_W'(prod_reg);
            end
            dou_pkg::OP_MAG:
            begin
                mag_reg <= mag_reg + (dou_pkg::MAG_W'(prod_reg) << dou_pkg::SUM_SPLIT);
            end
            dou_pkg::OP_MW_HI:
            begin
                wide_reg <= WIDE_W'(prod_reg);
            end
            dou_pkg::OP_WIDE:
            begin
                wide_reg <= wide_reg + (WIDE_W'(prod_reg) << dou_pkg::MA_W);
            end
            dou_pkg::OP_CAP:
            begin
                if (shifted > WIDE_W'(dou_pkg::DELTA_CAP))
                begin
                    dmag_reg <= dou_pkg::DELTA_W'(dou_pkg::DELTA_CAP);
                end
                else
                begin
                    dmag_reg <= shifted[dou_pkg::DELTA_W-1:0];
                end
                // x takes minus distance times sine, y plus distance times cosine
                dneg_reg <= cmd.axis_y ? (neg_reg ^ cs_neg_reg) : !(neg_reg ^ sn_neg_reg);
            end
            dou_pkg::OP_OUT:
            begin
                pos_x_reg  <= x_bias[ACC_W-1:FRAC_BITS];
                pos_y_reg  <= y_bias[ACC_W-1:FRAC_BITS];
                hd_out_reg <= hd_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.out_free   = !out_valid_reg || result_ready;
    assign result_valid    = out_valid_reg;
    assign pos_x_mm        = pos_x_reg;
    assign pos_y_mm        = pos_y_reg;
    assign heading_out_deg = hd_out_reg;

endmodule

[src/dou_ctrl.sv]
// sequencing state machine for the odometry update
// depends on dou_pkg and differential_odometry_update_macros.svh
`include "differential_odometry_update_macros.svh"

module dou_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  dou_pkg::dou_sts_t sts,
    output dou_pkg::dou_cmd_t cmd
);

    dou_pkg::dou_state_t state_reg;
    dou_pkg::dou_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dou_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dou_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = dou_pkg::ST_DELTA;
                end
            end
            dou_pkg::ST_DELTA:   state_next = dou_pkg::ST_SUM;
            dou_pkg::ST_SUM:     state_next = dou_pkg::ST_ABS;
            dou_pkg::ST_ABS:     state_next = dou_pkg::ST_QUAD;
            dou_pkg::ST_QUAD:    state_next = dou_pkg::ST_TRIG;
            dou_pkg::ST_TRIG:    state_next = dou_pkg::ST_MSUM_LO;
            dou_pkg::ST_MSUM_LO: state_next = dou_pkg::ST_MSUM_HI;
            dou_pkg::ST_MSUM_HI: state_next = dou_pkg::ST_MAG;
            dou_pkg::ST_MAG:     state_next = dou_pkg::ST_X_LO;
            dou_pkg::ST_X_LO:    state_next = dou_pkg::ST_X_HI;
            dou_pkg::ST_X_HI:    state_next = dou_pkg::ST_X_WIDE;
            dou_pkg::ST_X_WIDE:  state_next = dou_pkg::ST_X_CAP;
            dou_pkg::ST_X_CAP:   state_next = dou_pkg::ST_X_ACC;
            dou_pkg::ST_X_ACC:   state_next = dou_pkg::ST_Y_LO;
            dou_pkg::ST_Y_LO:    state_next = dou_pkg::ST_Y_HI;
            dou_pkg::ST_Y_HI:    state_next = dou_pkg::ST_Y_WIDE;
            dou_pkg::ST_Y_WIDE:  state_next = dou_pkg::ST_Y_CAP;
            dou_pkg::ST_Y_CAP:   state_next = dou_pkg::ST_Y_ACC;
            dou_pkg::ST_Y_ACC:   state_next = dou_pkg::ST_OUT;
            dou_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = dou_pkg::ST_IDLE;
                end
            end
            default:             state_next = dou_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample_ready = 1'b0;
        cmd.op       = dou_pkg::OP_NONE;
        cmd.axis_y   = 1'b0;
        unique case (state_reg)
            dou_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.op = dou_pkg::OP_LOAD;
                end
            end
            dou_pkg::ST_DELTA:   cmd.op = dou_pkg::OP_DELTA;
            dou_pkg::ST_SUM:     cmd.op = dou_pkg::OP_SUM;
            dou_pkg::ST_ABS:     cmd.op = dou_pkg::OP_ABS;
            dou_pkg::ST_QUAD:    cmd.op = dou_pkg::OP_QUAD;
            dou_pkg::ST_TRIG:    cmd.op = dou_pkg::OP_TRIG;
            dou_pkg::ST_MSUM_LO: cmd.op = dou_pkg::OP_MSUM_LO;
            dou_pkg::ST_MSUM_HI: cmd.op = dou_pkg::OP_MSUM_HI;
            dou_pkg::ST_MAG:     cmd.op = dou_pkg::OP_MAG;
            dou_pkg::ST_X_LO:    cmd.op = dou_pkg::OP_MW_LO;
            dou_pkg::ST_X_HI:    cmd.op = dou_pkg::OP_MW_HI;
            dou_pkg::ST_X_WIDE:  cmd.op = dou_pkg::OP_WIDE;
            dou_pkg::ST_X_CAP:   cmd.op = dou_pkg::OP_CAP;
            dou_pkg::ST_X_ACC:   cmd.op = dou_pkg::OP_ACC;
            dou_pkg::ST_Y_LO:
            begin
                cmd.op     = dou_pkg::OP_MW_LO;
                cmd.axis_y = 1'b1;
            end
            dou_pkg::ST_Y_HI:
            begin
                cmd.op     = dou_pkg::OP_MW_HI;
                cmd.axis_y = 1'b1;
            end
            dou_pkg::ST_Y_WIDE:
            begin
                cmd.op     = dou_pkg::OP_WIDE;
                cmd.axis_y = 1'b1;
            end
            dou_pkg::ST_Y_CAP:
            begin
                cmd.op     = dou_pkg::OP_CAP;
                cmd.axis_y = 1'b1;
            end
            dou_pkg::ST_Y_ACC:
            begin
                cmd.op     = dou_pkg::OP_ACC;
                cmd.axis_y = 1'b1;
            end
            dou_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op = dou_pkg::OP_OUT;
                end
            end
            default:
            begin
            end
        endcase
    end

    `DOU_ASSERT_NEXT(a_accept_starts, clk, rst_n, state_reg == dou_pkg::ST_IDLE && sample_valid, state_reg == dou_pkg::ST_DELTA, "accepted item did not start the sequence")
    `DOU_ASSERT_NEXT(a_out_holds, clk, rst_n, state_reg == dou_pkg::ST_OUT && !sts.out_free, state_reg == dou_pkg::ST_OUT, "result dropped while output slot busy")
    `DOU_ASSERT_SAME(a_out_slot_free, clk, rst_n, cmd.op == dou_pkg::OP_OUT, sts.out_free, "output loaded over a waiting result")
    `DOU_ASSERT_NEXT(a_y_then_out, clk, rst_n, state_reg == dou_pkg::ST_Y_ACC, state_reg == dou_pkg::ST_OUT, "y update not followed by output")

endmodule

[src/differential_odometry_update.sv]
// top level of the dead-reckoning odometry update block
// depends on dou_pkg, dou_ifs, dou_ctrl and dou_dp
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  sample   | in  | valid / ready | left_count, right_count, heading_deg
//  result   | out | valid / ready | pos_x_mm, pos_y_mm, heading_out_deg
//  cfg      | in  | cfg_wr_en     | cfg_wr_data (mm per tick, Q8.16)
//
//  an item is taken in the accept cycle, then runs 19 sequencer steps through
//  the shared 29x24 multiplier (two passes for distance, two per axis)
//  the result register takes the item in the final output step; a waiting result
//  stalls only the final output step, the next item is taken once it loads
//  asynchronous active-low reset clears previous counts, both accumulators,
//  the output valid and sets the scale register to its default

module differential_odometry_update #(
    parameter int unsigned FRAC_BITS = dou_pkg::FRAC_BITS_DEF,
    parameter int unsigned TRIG_BITS = dou_pkg::TRIG_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dou_sample_if.sink                  sample,
    dou_result_if.source                result,
    input  logic                        cfg_wr_en,
    input  logic [dou_pkg::SCALE_W-1:0] cfg_wr_data
);

    dou_pkg::dou_cmd_t cmd;
    dou_pkg::dou_sts_t sts;
    logic              sample_ready;

    dou_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    dou_dp #(
        .FRAC_BITS (FRAC_BITS),
        .TRIG_BITS (TRIG_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .left_count      (sample.left_count),
        .right_count     (sample.right_count),
        .heading_deg     (sample.heading_deg),
        .result_ready    (result.ready),
        .result_valid    (result.valid),
        .pos_x_mm        (result.pos_x_mm),
        .pos_y_mm        (result.pos_y_mm),
        .heading_out_deg (result.heading_out_deg)
    );

    assign sample.ready = sample_ready;

endmodule

[bench/differential_odometry_update_tb.sv]
`timescale 1ns / 1ps
// testbench for differential_odometry_update: random and directed encoder samples,
// a self-contained pose predictor and an in-order checker of position results
// depends on dou_pkg, dou_ifs and the odometry update rtl
module differential_odometry_update_tb;

    localparam int FRAC = dou_pkg::FRAC_BITS_DEF;
    localparam int TRIG = dou_pkg::TRIG_BITS_DEF;
    localparam int SHIFT = 17 + TRIG - FRAC;
    localparam int DEG_TURN = 360;
    localparam int DEG_RIGHT = 90;
    localparam int DEG_HALF_RIGHT = 45;
    localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
    localparam longint unsigned RAD_Q30 = 64'd18740330;
    localparam longint unsigned HALF_LSB = 64'd1 << (29 - TRIG);
    localparam logic [4:0][7:0] SIN_DIV = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110};
    localparam logic [4:0][7:0] COS_DIV = {8'd2, 8'd12, 8'd30, 8'd56, 8'd90};
    localparam longint DELTA_LIMIT = 64'sd1 <<< 62;
    localparam longint ACC_MAX = (64'sd1 <<< (31 + FRAC)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint ACC_ONE = 64'sd1 <<< FRAC;
    localparam int IDLE_PCT = 9;
    localparam int HOLD_AT = 700;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_CAP = 50;

    typedef struct packed {
        logic [dou_pkg::CNT_W-1:0]  left;
        logic [dou_pkg::CNT_W-1:0]  right;
        logic [dou_pkg::HEAD_W-1:0] hdg;
    } odo_sample_t;

    typedef struct packed {
        logic signed [dou_pkg::POS_W-1:0]  x;
        logic signed [dou_pkg::POS_W-1:0]  y;
        logic signed [dou_pkg::HEAD_W-1:0] hdg;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [dou_pkg::SCALE_W-1:0] cfg_wr_data;

    dou_sample_if sample_ch ();
    dou_result_if result_ch ();

    differential_odometry_update uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    odo_sample_t sample_backlog[$];
    pose_t pose_expected[$];
    odo_sample_t next_sample;
    pose_t seen_pose;
    pose_t want_pose;

    logic [dou_pkg::SCALE_W-1:0] scale_model = dou_pkg::SCALE_RESET;
    logic [31:0] track_left = '0;
    logic [31:0] track_right = '0;
    longint x_acc = 0;
    longint y_acc = 0;

    logic [31:0] walk_left = '0;
    logic [31:0] walk_right = '0;
    logic sample_took = 1'b0;
    bit steady = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int samples_taken = 0;
    int poses_seen = 0;
    int mismatches = 0;
    int scale_loads = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // sine or cosine of 0..45 degrees, truncating horner series in q30
    function automatic longint unsigned octant_trig(input int unsigned deg, input bit want_cos);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned acc;
        ang = 64'(deg) * RAD_Q30;
        ang_sq = (ang * ang) >> 30;
        acc = UNIT_Q30;
        for (int i = 0; i < 5; i++)
        begin
            acc = UNIT_Q30 - (((ang_sq * acc) >> 30) / 64'(want_cos ? COS_DIV[i] : SIN_DIV[i]));
        end
        if (!want_cos)
        begin
            acc = (ang * acc) >> 30;
        end
        return (acc + HALF_LSB) >> (30 - TRIG);
    endfunction

    function automatic longint unsigned quarter_trig(input int unsigned deg, input bit want_cos);
        if (deg <= DEG_HALF_RIGHT)
        begin
            return octant_trig(deg, want_cos);
        end
        return octant_trig(DEG_RIGHT - deg, !want_cos);
    endfunction

    function automatic longint axis_delta(input longint unsigned mag, input bit neg,
                                          input longint trig);
        logic [127:0] wide;
        longint d;
        wide = 128'(mag) * 128'(trig < 0 ? -trig : trig);
        wide = wide >> SHIFT;
        d = (wide > 128'(DELTA_LIMIT)) ? DELTA_LIMIT : longint'(wide[63:0]);
        return (neg != (trig < 0)) ? -d : d;
    endfunction

    function automatic longint clamp_acc(input longint acc, input longint d);
        longint s;
        s = acc + d;
        if (s > ACC_MAX)
        begin
            return ACC_MAX;
        end
        if (s < ACC_MIN)
        begin
            return ACC_MIN;
        end
        return s;
    endfunction

    function automatic pose_t advance_pose(input logic [31:0] cl, input logic [31:0] cr,
                                           input logic signed [15:0] hd);
        logic signed [31:0] dl;
        logic signed [31:0] dr;
        longint sum;
        longint sn;
        longint cs;
        longint unsigned mag;
        longint unsigned sb;
        longint unsigned cb;
        int h;
        dou_pkg::dou_quad_t quad;
        pose_t p;
        dl = cl - track_left;
        dr = cr - track_right;
        track_left = cl;
        track_right = cr;
        sum = longint'(dl) + longint'(dr);
        h = ((int'(hd) % DEG_TURN) + DEG_TURN) % DEG_TURN;
        quad = dou_pkg::dou_quad_t'(h / DEG_RIGHT);
        sb = quarter_trig(h % DEG_RIGHT, 1'b0);
        cb = quarter_trig(h % DEG_RIGHT, 1'b1);
        case (quad)
            dou_pkg::QUAD_0:
            begin
                sn = longint'(sb);
                cs = longint'(cb);
            end
            dou_pkg::QUAD_1:
            begin
                sn = longint'(cb);
                cs = -longint'(sb);
            end
            dou_pkg::QUAD_2:
            begin
                sn = -longint'(sb);
                cs = -longint'(cb);
            end
            default:
            begin
                sn = -longint'(cb);
                cs = longint'(sb);
            end
        endcase
        mag = 64'(sum < 0 ? -sum : sum) * 64'(scale_model);
        x_acc = clamp_acc(x_acc, -axis_delta(mag, sum < 0, sn));
        y_acc = clamp_acc(y_acc, axis_delta(mag, sum < 0, cs));
        p.x = 32'(x_acc / ACC_ONE);
        p.y = 32'(y_acc / ACC_ONE);
        p.hdg = hd;
        return p;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_CAP)
        begin
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     poses_seen, what, got, want);
        end
        mismatches++;
    endtask

    task automatic queue_sample(input logic [31:0] l, input logic [31:0] r,
                                input logic [15:0] h);
        odo_sample_t s;
        s.left = l;
        s.right = r;
        s.hdg = h;
        sample_backlog.push_back(s);
        walk_left = l;
        walk_right = r;
    endtask

    task automatic queue_random(input int count);
        int pick;
        logic [31:0] l;
        logic [31:0] r;
        logic [15:0] h;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                l = walk_left + 32'($urandom_range(4000)) - 32'd2000;
                r = walk_right + 32'($urandom_range(4000)) - 32'd2000;
            end
            else if (pick < 85)
            begin
                l = $urandom;
                r = $urandom;
            end
            else if (pick < 93)
            begin
                l = walk_left + 32'h7FFF_FFF8 + 32'($urandom_range(15));
                r = walk_right - 32'h7FFF_FFF8 - 32'($urandom_range(15));
            end
            else
            begin
                l = walk_left;
                r = walk_right;
            end
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                h = 16'($urandom_range(DEG_TURN - 1));
            end
            else if (pick < 85)
            begin
                h = 16'($urandom);
            end
            else
            begin
                h = 16'(DEG_HALF_RIGHT * int'($urandom_range(7))
                        + DEG_TURN * (int'($urandom_range(160)) - 80));
            end
            queue_sample(l, r, h);
        end
    endtask

    task automatic settle();
        while (sample_backlog.size() != 0 || sample_ch.valid || pose_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_scale(input logic [dou_pkg::SCALE_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        scale_loads++;
    endtask

    // sender: a new item is offered only after the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!sample_ch.valid || sample_took))
        begin
            if (sample_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                next_sample = sample_backlog.pop_front();
                sample_ch.left_count <= next_sample.left;
                sample_ch.right_count <= next_sample.right;
                sample_ch.heading_deg <= next_sample.hdg;
                sample_ch.valid <= 1'b1;
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off that backs up the block
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (!hold_done && poses_seen >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            sample_took <= sample_ch.valid && sample_ch.ready;
            if (cfg_wr_en)
            begin
                scale_model = cfg_wr_data;
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                pose_expected.push_back(advance_pose(sample_ch.left_count,
                                                     sample_ch.right_count,
                                                     sample_ch.heading_deg));
                samples_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                seen_pose.x = result_ch.pos_x_mm;
                seen_pose.y = result_ch.pos_y_mm;
                seen_pose.hdg = result_ch.heading_out_deg;
                if (pose_expected.size() == 0)
                begin
                    flag_mismatch("result with nothing pending, x", seen_pose.x, 0);
                end
                else
                begin
                    want_pose = pose_expected.pop_front();
                    if (seen_pose.x !== want_pose.x)
                    begin
                        flag_mismatch("pos_x_mm", seen_pose.x, want_pose.x);
                    end
                    if (seen_pose.y !== want_pose.y)
                    begin
                        flag_mismatch("pos_y_mm", seen_pose.y, want_pose.y);
                    end
                    if (seen_pose.hdg !== want_pose.hdg)
                    begin
                        flag_mismatch("heading_out_deg", seen_pose.hdg, want_pose.hdg);
                    end
                end
                poses_seen++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still pending", pose_expected.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.left_count = '0;
        sample_ch.right_count = '0;
        sample_ch.heading_deg = '0;
        result_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first sample against zero counts, quadrant edges, heading wrap
        queue_sample(32'd1000, 32'd1000, 16'd0);
        queue_sample(32'd2000, 32'd2000, 16'd90);
        queue_sample(32'd3000, 32'd3000, 16'd180);
        queue_sample(32'd4000, 32'd4000, 16'd270);
        queue_sample(32'd5000, 32'd5000, 16'd45);
        queue_sample(32'd6000, 32'd6000, 16'd44);
        queue_sample(32'd7000, 32'd7000, 16'd46);
        queue_sample(32'd8000, 32'd8000, 16'd359);
        queue_sample(32'd9000, 32'd9000, 16'd360);
        queue_sample(32'd10000, 32'd10000, 16'hFFFF);
        queue_sample(32'd11000, 32'd11000, 16'hFE98);
        queue_sample(32'd12000, 32'd12000, 16'h8000);
        queue_sample(32'd13000, 32'd13000, 16'h7FFF);
        queue_sample(32'd13000, 32'd13000, 16'd89);
        queue_sample(32'd12000, 32'd14000, 16'd135);
        queue_sample(32'd0, 32'd0, 16'd225);
        // largest deltas, count wrap and accumulator saturation both ways
        queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0);
        queue_sample(32'h8000_0000, 32'h8000_0000, 16'd90);
        queue_sample(32'd0, 32'd0, 16'd0);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'd315);
        queue_sample(32'hFFFF_FFFF, 32'd1, 16'd180);
        queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd270);
        settle();

        load_scale('0);
        queue_random(150);
        settle();
        load_scale('1);
        queue_random(200);
        settle();
        load_scale(24'd1);
        queue_random(150);
        settle();
        for (int ph = 0; ph < 5; ph++)
        begin
            steady = (ph == 2);
            if (ph == 4)
            begin
                load_scale(dou_pkg::SCALE_RESET);
            end
            else if ($urandom_range(1) != 0)
            begin
                load_scale(24'($urandom_range(24'hFF_FFFF)));
            end
            else
            begin
                load_scale(24'($urandom_range(120000, 2000)));
            end
            queue_random(240);
            settle();
        end
        steady = 1'b0;

        if (pose_expected.size() != 0)
        begin
            flag_mismatch("results never produced", pose_expected.size(), 0);
        end
        $display("covered %0d samples and %0d position results over %0d scale settings",
                 samples_taken, poses_seen, scale_loads);
        $display("including count wrap, saturation, a long output hold-off; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
